// ----- src/ktr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ktr_pkg
// Shared types, fixed-point constants and latencies of the color temperature
// to RGB/HSB converter.
// ----------------------------------------------------------------------------
package ktr_pkg;

	// input and log2 formats
	localparam int KEL_W   = 16;
	localparam int E_W     = 4;
	localparam int LG_FRAC = 24;
	localparam int LG_W    = E_W + LG_FRAC;
	localparam int MANT_W  = 31;

	// power curve formats
	localparam int Y_W   = 26;
	localparam int N_W   = 3;
	localparam int F_W   = 25;
	localparam int X_W   = 30;
	localparam int T_W   = 31;
	localparam int S_W   = 32;
	localparam int PR_W  = 57;
	localparam int SER_N = 12;

	// log curve formats
	localparam int LN_W = 28;
	localparam int V_W  = 52;

	// pipeline latencies
	localparam int LG_LAT  = LG_FRAC + 1;
	localparam int LOG_LAT = 3;
	localparam int EXP_LAT = 3 + 3 * SER_N + 2;

	// kelvin breakpoints
	localparam logic [KEL_W-1:0] KEL_LO_MAX = 16'd6600;
	localparam logic [KEL_W-1:0] KEL_BZ_MAX = 16'd1900;
	localparam logic [KEL_W-1:0] OFS_BLU    = 16'd1000;
	localparam logic [KEL_W-1:0] OFS_POW    = 16'd6000;

	// curve coefficients, Q16 gains and Q24 exponents
	localparam logic [31:0] LN2_Q30   = 32'd744261118;
	localparam logic [31:0] GRN_LO_C1 = 32'd6518919;
	localparam logic [31:0] GRN_LO_C0 = 32'd10559132;
	localparam logic [31:0] BLU_C1    = 32'd9077898;
	localparam logic [31:0] BLU_C0    = 32'd19991416;
	localparam logic [31:0] RED_A     = 32'd21607136;
	localparam logic [31:0] RED_P     = 32'd2234805;
	localparam logic [31:0] GRN_HI_A  = 32'd18882375;
	localparam logic [31:0] GRN_HI_P  = 32'd1266929;

	// bit-by-bit log2 in Q24, evaluated at elaboration for constants
	function automatic logic [LG_W-1:0] lg2_q24_f(input logic [KEL_W-1:0] x);
		logic [63:0]     m;
		logic [LG_W-1:0] r;
		int              e;
		e = 0;
		for (int j = 1; j < KEL_W; j++)
			if (x[j]) e = j;
		m = 64'(x) << (30 - e);
		r = LG_W'(e) << LG_FRAC;
		for (int i = LG_FRAC - 1; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= 64'h8000_0000) begin
				m = m >> 1;
				r[i] = 1'b1;
			end
		end
		return r;
	endfunction

	localparam logic [LG_W-1:0] LG2_100 = lg2_q24_f(16'd100);
	localparam logic [63:0] LN_100 = (64'(LG2_100) * 64'(LN2_Q30)) >> 30;
	localparam logic [63:0] K_GRN = 64'(GRN_LO_C1) * LN_100 + (64'(GRN_LO_C0) << 24);
	localparam logic [63:0] K_BLU = 64'(BLU_C1) * LN_100 + (64'(BLU_C0) << 24);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [8:0] hue;
		logic [6:0] saturation;
		logic [6:0] brightness;
	} res_t;

endpackage
`default_nettype wire

// ----- src/ktr_dly.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ktr_dly
// Enable-gated delay line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module ktr_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] dl_s [N];

	// first tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dl_s[0] <= '0;
		end else if (en) begin
			dl_s[0] <= d;
		end
	end

	// remaining taps
	for (genvar i = 1; i < N; i++) begin : g_tap
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dl_s[i] <= '0;
			end else if (en) begin
				dl_s[i] <= dl_s[i-1];
			end
		end
	end

	assign q = dl_s[N-1];

endmodule
`default_nettype wire

// ----- src/ktr_lg2.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ktr_lg2
// Pipelined log2 in Q24: one normalize stage, then one squaring stage per
// fraction bit.
// ----------------------------------------------------------------------------
module ktr_lg2 import ktr_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [KEL_W-1:0] x,
	output logic [LG_W-1:0]  lg
);

	logic [MANT_W-1:0] mant_s [LG_FRAC+1];
	logic [LG_W-1:0]   acc_s  [LG_FRAC+1];
	logic [E_W-1:0]    e_w;

	// leading one position
	always_comb begin
		e_w = '0;
		for (int j = 1; j < KEL_W; j++)
			if (x[j]) e_w = E_W'(j);
	end

	// normalize to a Q30 mantissa
	always_ff @(posedge clk) begin
		if (en) begin
			mant_s[0] <= MANT_W'(x) << (5'(MANT_W - 1) - 5'(e_w));
			acc_s[0]  <= {e_w, {LG_FRAC{1'b0}}};
		end
	end

	// square, renormalize, emit one bit
	for (genvar i = 0; i < LG_FRAC; i++) begin : g_bit
		logic [2*MANT_W-1:0] sq_w;
		assign sq_w = 62'(mant_s[i]) * 62'(mant_s[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				mant_s[i+1] <= sq_w[61] ? sq_w[61:31] : sq_w[60:30];
				acc_s[i+1]  <= acc_s[i] |
					(sq_w[61] ? (LG_W'(1) << (LG_FRAC - 1 - i)) : '0);
			end
		end
	end

	assign lg = acc_s[LG_FRAC];

endmodule
`default_nettype wire

// ----- src/ktr_exp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ktr_exp
// Power curve a * 2^(-p*lr): exponent split, 12-term exp series in Q30 with
// divide-by-constant through reciprocal and one correction, final scale.
// ----------------------------------------------------------------------------
module ktr_exp import ktr_pkg::*; #(
	parameter logic [31:0] A = RED_A,
	parameter logic [31:0] P = RED_P
) (
	input  logic            clk,
	input  logic            en,
	input  logic [LG_W-1:0] lr,
	output logic [7:0]      q
);

	logic [Y_W-1:0]  y_s1;
	logic [N_W-1:0]  n_s2;
	logic [F_W-1:0]  f_s2;
	logic [63:0]     yp_w;
	logic [N_W-1:0]  n_w;
	logic [26:0]     fw_w;
	logic [63:0]     xp_w;

	logic [T_W-1:0]  trm_s [SER_N+1];
	logic [S_W-1:0]  sum_s [SER_N+1];
	logic [X_W-1:0]  xv_s  [SER_N+1];
	logic [N_W-1:0]  nv_s  [SER_N+1];

	logic [PR_W-1:0] pr_s;
	logic [N_W-1:0]  nf_s;
	logic [63:0]     pp_w;
	logic [PR_W-1:0] sh_w;
	logic [7:0]      cv_s;

	// scaled exponent
	assign yp_w = 64'(P) * 64'(lr);
	always_ff @(posedge clk) begin
		if (en) y_s1 <= yp_w[Y_W+23:24];
	end

	// integer shift and fractional part
	assign n_w  = N_W'(y_s1[Y_W-1:24]) + N_W'(1);
	assign fw_w = {n_w, 24'd0} - 27'(y_s1);
	always_ff @(posedge clk) begin
		if (en) begin
			n_s2 <= n_w;
			f_s2 <= fw_w[F_W-1:0];
		end
	end

	// series argument in Q30
	assign xp_w = 64'(f_s2) * 64'(LN2_Q30);
	always_ff @(posedge clk) begin
		if (en) begin
			xv_s[0]  <= xp_w[X_W+23:24];
			nv_s[0]  <= n_s2;
			trm_s[0] <= T_W'(1) << 30;
			sum_s[0] <= S_W'(1) << 30;
		end
	end

	// one series term per three stages
	for (genvar k = 0; k < SER_N; k++) begin : g_term
		localparam int          K  = k + 1;
		localparam logic [63:0] MV = 64'h1_0000_0000 / K;
		logic [X_W-1:0] ta_s, tb_s, qe_s;
		logic [S_W-1:0] sa_s, sb_s;
		logic [X_W-1:0] xa_s, xb_s;
		logic [N_W-1:0] na_s, nb_s;
		logic [63:0]    ta_w, qp_w;
		logic [33:0]    r_w;
		logic [T_W-1:0] tn_w;

		// term times argument
		assign ta_w = 64'(trm_s[k]) * 64'(xv_s[k]);
		always_ff @(posedge clk) begin
			if (en) begin
				ta_s <= ta_w[59:30];
				sa_s <= sum_s[k];
				xa_s <= xv_s[k];
				na_s <= nv_s[k];
			end
		end

		// quotient estimate by reciprocal
		assign qp_w = 64'(ta_s) * 64'(MV[32:0]);
		always_ff @(posedge clk) begin
			if (en) begin
				qe_s <= qp_w[61:32];
				tb_s <= ta_s;
				sb_s <= sa_s;
				xb_s <= xa_s;
				nb_s <= na_s;
			end
		end

		// correct by one and accumulate
		assign r_w  = 34'(tb_s) - 34'(qe_s) * 34'(K);
		assign tn_w = T_W'(qe_s) + T_W'(r_w >= 34'(K));
		always_ff @(posedge clk) begin
			if (en) begin
				trm_s[k+1] <= tn_w;
				sum_s[k+1] <= sb_s + S_W'(tn_w);
				xv_s[k+1]  <= xb_s;
				nv_s[k+1]  <= nb_s;
			end
		end
	end

	// gain times series
	assign pp_w = 64'(A) * 64'(sum_s[SER_N]);
	always_ff @(posedge clk) begin
		if (en) begin
			pr_s <= pp_w[PR_W-1:0];
			nf_s <= nv_s[SER_N];
		end
	end

	// final shift and clamp
	assign sh_w = pr_s >> (6'd46 + 6'(nf_s));
	always_ff @(posedge clk) begin
		if (en) cv_s <= (|sh_w[PR_W-1:8]) ? 8'd255 : sh_w[7:0];
	end

	assign q = cv_s;

endmodule
`default_nettype wire

// ----- src/ktr_hsb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ktr_hsb
// RGB to hue, saturation and brightness in four stages, with table
// reciprocals for the two small divisions.
// ----------------------------------------------------------------------------
module ktr_hsb import ktr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld,
	input  rgb_t rgb,
	output logic vld_o,
	output res_t res
);

	typedef enum logic [1:0] {
		SEC_R = 2'd0,
		SEC_G = 2'd1,
		SEC_B = 2'd2
	} sec_t;

	logic [31:0] rtab [256];
	logic [6:0]  btab [256];

	// reciprocal of twice the index, and brightness by max channel
	for (genvar gi = 0; gi < 256; gi++) begin : g_tab
		localparam logic [63:0] BV = (200 * gi + 255) / 510;
		if (gi == 0) begin : g_zero
			assign rtab[gi] = '0;
		end else begin : g_rec
			localparam logic [63:0] RV = 64'h1_0000_0000 / (2 * gi);
			assign rtab[gi] = RV[31:0];
		end
		assign btab[gi] = BV[6:0];
	end

	// stage 1: max, min, sector and numerators
	logic [7:0]         mx_w, mn_w, d_w;
	sec_t               sec_w;
	logic signed [8:0]  num_w;
	logic signed [17:0] hn_w;

	always_comb begin
		mx_w = (rgb.red > rgb.green) ? rgb.red : rgb.green;
		if (rgb.blue > mx_w) mx_w = rgb.blue;
		mn_w = (rgb.red < rgb.green) ? rgb.red : rgb.green;
		if (rgb.blue < mn_w) mn_w = rgb.blue;
		d_w = mx_w - mn_w;
		if (mx_w == rgb.red) sec_w = SEC_R;
		else if (mx_w == rgb.green) sec_w = SEC_G;
		else sec_w = SEC_B;
		case (sec_w)
			SEC_R:   num_w = $signed({1'b0, rgb.green}) - $signed({1'b0, rgb.blue});
			SEC_G:   num_w = $signed({1'b0, rgb.blue}) - $signed({1'b0, rgb.red});
			default: num_w = $signed({1'b0, rgb.red}) - $signed({1'b0, rgb.green});
		endcase
		hn_w = 18'sd120 * 18'(num_w) + 18'sd121 * $signed({10'd0, d_w});
	end

	logic        v_s1;
	logic [7:0]  mx_s1, d_s1;
	logic [15:0] sn_s1, hn_s1;
	sec_t        sec_s1;
	rgb_t        rgb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1  <= mx_w;
			d_s1   <= d_w;
			sn_s1  <= 16'(d_w) * 16'd200 + 16'(mx_w);
			hn_s1  <= hn_w[15:0];
			sec_s1 <= sec_w;
			rgb_s1 <= rgb;
		end
	end

	// stage 2: quotient estimates
	logic [47:0] qsp_w, qhp_w;
	logic        v_s2;
	logic [7:0]  qs_s2, qh_s2, mx_s2, d_s2;
	logic [15:0] sn_s2, hn_s2;
	sec_t        sec_s2;
	rgb_t        rgb_s2;

	assign qsp_w = 48'(sn_s1) * 48'(rtab[mx_s1]);
	assign qhp_w = 48'(hn_s1) * 48'(rtab[d_s1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qs_s2  <= qsp_w[39:32];
			qh_s2  <= qhp_w[39:32];
			mx_s2  <= mx_s1;
			d_s2   <= d_s1;
			sn_s2  <= sn_s1;
			hn_s2  <= hn_s1;
			sec_s2 <= sec_s1;
			rgb_s2 <= rgb_s1;
		end
	end

	// stage 3: one-step correction, brightness lookup
	logic [16:0] rs_w, rh_w, ds_w, dh_w;
	logic        v_s3;
	logic [6:0]  sat_s3, bri_s3, hq_s3;
	logic [7:0]  d_s3;
	sec_t        sec_s3;
	rgb_t        rgb_s3;

	assign ds_w = {8'd0, mx_s2, 1'b0};
	assign dh_w = {8'd0, d_s2, 1'b0};
	assign rs_w = 17'(sn_s2) - 17'(qs_s2) * ds_w;
	assign rh_w = 17'(hn_s2) - 17'(qh_s2) * dh_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s3 <= (mx_s2 == 8'd0) ? 7'd0 : 7'(qs_s2) + 7'(rs_w >= ds_w);
			hq_s3  <= 7'(qh_s2) + 7'(rh_w >= dh_w);
			bri_s3 <= btab[mx_s2];
			d_s3   <= d_s2;
			sec_s3 <= sec_s2;
			rgb_s3 <= rgb_s2;
		end
	end

	// stage 4: sector offset and wrap
	logic [9:0] off_w, tmp_w, hue_w;
	logic       v_s4;
	res_t       res_s4;

	always_comb begin
		case (sec_s3)
			SEC_R:   off_w = 10'd0;
			SEC_G:   off_w = 10'd120;
			default: off_w = 10'd240;
		endcase
		tmp_w = 10'(hq_s3) + off_w;
		if (d_s3 == 8'd0) hue_w = 10'd0;
		else if (tmp_w < 10'd60) hue_w = tmp_w + 10'd300;
		else hue_w = tmp_w - 10'd60;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4.red        <= rgb_s3.red;
			res_s4.green      <= rgb_s3.green;
			res_s4.blue       <= rgb_s3.blue;
			res_s4.hue        <= hue_w[8:0];
			res_s4.saturation <= sat_s3;
			res_s4.brightness <= bri_s3;
		end
	end

	assign vld_o = v_s4;
	assign res   = res_s4;

endmodule
`default_nettype wire

// ----- src/kelvin_to_rgb_and_hsb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kelvin_to_rgb_and_hsb
// Color temperature to RGB and hue/saturation/brightness converter.
// ----------------------------------------------------------------------------
// Takes one kelvin item per clock while kelvin_stall is low and returns its
// color after 25 stages of bit-serial log2 (one squaring multiplier per
// fraction bit), 41 stages for the power curves (three stages per exp
// series term), four HSB stages and the output register. All stages advance
// together; a skid register behind the output catches the item in flight
// when the consumer stalls, and kelvin_stall is high only while that skid
// register is full.
module kelvin_to_rgb_and_hsb import ktr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             kelvin_valid,
	output logic             kelvin_stall,
	input  logic [KEL_W-1:0] kelvin,
	output logic             color_valid,
	input  logic             color_stall,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [8:0]       hue,
	output logic [6:0]       saturation,
	output logic [6:0]       brightness
);

	logic en, in_acc;
	logic out_v_q, skid_v_q;
	res_t out_q, skid_q;

	assign en     = ~skid_v_q;
	assign in_acc = kelvin_valid & en;

	// log arguments: curve argument on lane a, blue argument on lane b
	logic             lo_w, bz_w;
	logic [KEL_W-1:0] xa_w, xb_w;
	logic [LG_W-1:0]  lga_w, lgb_w;

	assign lo_w = kelvin <= KEL_LO_MAX;
	assign bz_w = kelvin <= KEL_BZ_MAX;
	assign xa_w = lo_w ? kelvin : kelvin - OFS_POW;
	assign xb_w = kelvin - OFS_BLU;

	ktr_lg2 u_lga (.clk(clk), .en(en), .x(xa_w), .lg(lga_w));
	ktr_lg2 u_lgb (.clk(clk), .en(en), .x(xb_w), .lg(lgb_w));

	logic [2:0] sb_w;
	ktr_dly #(.W(3), .N(LG_LAT)) u_sb (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({in_acc, lo_w, bz_w}), .q(sb_w)
	);

	// power curves for the high range
	logic [LG_W-1:0] lr_w;
	logic [7:0]      red_p, grn_p;

	assign lr_w = (lga_w > LG2_100) ? lga_w - LG2_100 : '0;

	ktr_exp #(.A(RED_A), .P(RED_P)) u_red (
		.clk(clk), .en(en), .lr(lr_w), .q(red_p)
	);
	ktr_exp #(.A(GRN_HI_A), .P(GRN_HI_P)) u_grn (
		.clk(clk), .en(en), .lr(lr_w), .q(grn_p)
	);

	// log curves for the low range: natural log
	logic [63:0]     lnga_w, lnbb_w;
	logic [LN_W-1:0] lng_s1, lnb_s1;

	assign lnga_w = 64'(lga_w) * 64'(LN2_Q30);
	assign lnbb_w = 64'(sb_w[0] ? '0 : lgb_w) * 64'(LN2_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			lng_s1 <= lnga_w[LN_W+29:30];
			lnb_s1 <= lnbb_w[LN_W+29:30];
		end
	end

	// gain times log
	logic [63:0]    vgp_w, vbp_w;
	logic [V_W-1:0] vg_s2, vb_s2;

	assign vgp_w = 64'(GRN_LO_C1) * 64'(lng_s1);
	assign vbp_w = 64'(BLU_C1) * 64'(lnb_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			vg_s2 <= vgp_w[V_W-1:0];
			vb_s2 <= vbp_w[V_W-1:0];
		end
	end

	// subtract offset, clamp
	logic [V_W-1:0] dg_w, db_w;
	logic [7:0]     gl_s3, bl_s3;

	assign dg_w = vg_s2 - K_GRN[V_W-1:0];
	assign db_w = vb_s2 - K_BLU[V_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			if (vg_s2 <= K_GRN[V_W-1:0]) gl_s3 <= 8'd0;
			else gl_s3 <= (|dg_w[V_W-1:48]) ? 8'd255 : dg_w[47:40];
			if (vb_s2 <= K_BLU[V_W-1:0]) bl_s3 <= 8'd0;
			else bl_s3 <= (|db_w[V_W-1:48]) ? 8'd255 : db_w[47:40];
		end
	end

	// align valid, range and low-range channels with the power curves
	logic [1:0]  vl_w;
	logic [15:0] glb_w;

	ktr_dly #(.W(2), .N(EXP_LAT)) u_vl (
		.clk(clk), .arst_n(arst_n), .en(en), .d(sb_w[2:1]), .q(vl_w)
	);
	ktr_dly #(.W(16), .N(EXP_LAT - LOG_LAT)) u_glb (
		.clk(clk), .arst_n(arst_n), .en(en), .d({gl_s3, bl_s3}), .q(glb_w)
	);

	// channel select and HSB
	rgb_t rgb_w;
	logic pv_w;
	res_t pd_w;

	assign rgb_w.red   = vl_w[0] ? 8'd255 : red_p;
	assign rgb_w.green = vl_w[0] ? glb_w[15:8] : grn_p;
	assign rgb_w.blue  = vl_w[0] ? glb_w[7:0] : 8'd255;

	ktr_hsb u_hsb (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(vl_w[1]), .rgb(rgb_w),
		.vld_o(pv_w), .res(pd_w)
	);

	// output register with skid
	logic take;
	assign take = out_v_q & ~color_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) skid_v_q <= 1'b0;
		end else if (pv_w) begin
			out_v_q <= 1'b1;
			if (out_v_q && !take) skid_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) out_q <= skid_q;
		end else if (pv_w) begin
			if (!out_v_q || take) out_q <= pd_w;
			else skid_q <= pd_w;
		end
	end

	assign kelvin_stall = skid_v_q;
	assign color_valid  = out_v_q;
	assign red          = out_q.red;
	assign green        = out_q.green;
	assign blue         = out_q.blue;
	assign hue          = out_q.hue;
	assign saturation   = out_q.saturation;
	assign brightness   = out_q.brightness;

endmodule
`default_nettype wire

// ----- src/ktr_chk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ktr_chk
// Port-level checks of the color temperature converter.
// ----------------------------------------------------------------------------
module ktr_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        kelvin_valid,
	input logic        kelvin_stall,
	input logic [15:0] kelvin,
	input logic        color_valid,
	input logic        color_stall,
	input logic [7:0]  red,
	input logic [7:0]  green,
	input logic [7:0]  blue,
	input logic [8:0]  hue,
	input logic [6:0]  saturation,
	input logic [6:0]  brightness
);

	// one of red or blue is always saturated by the curves
	a_rb_full: assert property (@(posedge clk) disable iff (!arst_n)
		color_valid |-> red == 8'd255 || blue == 8'd255)
		else $error("neither red nor blue at full scale");

	// hsb fields stay in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		color_valid |-> hue < 9'd360 && saturation <= 7'd100 && brightness <= 7'd100)
		else $error("hsb field out of range");

	// gray gives zero hue and saturation
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		color_valid && red == green && green == blue |-> hue == 9'd0 && saturation == 7'd0)
		else $error("gray item with nonzero hue or saturation");

	// upstream stall only follows a downstream stall
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(kelvin_stall) |-> $past(color_valid && color_stall))
		else $error("input stalled without output backpressure");

	// stalled item stays valid with hue and green unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		color_valid && color_stall |=> color_valid && $stable(hue) && $stable(green))
		else $error("stalled item changed");

endmodule

bind kelvin_to_rgb_and_hsb ktr_chk u_ktr_chk (.*);
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the color temperature converter against a bit-exact predictor of
// its fixed-point curves and HSB rounding, under directed and random kelvin
// values and several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module testbench;
	import ktr_pkg::*;

	localparam int LATENCY = 71;
	localparam int WATCHDOG_LIMIT = 20000;

	logic             clk;
	logic             arst_n;
	logic             kelvin_valid;
	logic             kelvin_stall;
	logic [KEL_W-1:0] kelvin;
	logic             color_valid;
	logic             color_stall;
	logic [7:0]       red;
	logic [7:0]       green;
	logic [7:0]       blue;
	logic [8:0]       hue;
	logic [6:0]       saturation;
	logic [6:0]       brightness;

	res_t colors_pending[$];
	int   errors;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   idle_cycles;

	kelvin_to_rgb_and_hsb dut (
		.clk(clk), .arst_n(arst_n),
		.kelvin_valid(kelvin_valid), .kelvin_stall(kelvin_stall), .kelvin(kelvin),
		.color_valid(color_valid), .color_stall(color_stall),
		.red(red), .green(green), .blue(blue),
		.hue(hue), .saturation(saturation), .brightness(brightness)
	);

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// bit-serial log2 of a 16-bit value, Q24
	function automatic logic [63:0] log2_fixed(input logic [15:0] x);
		logic [63:0] m;
		logic [63:0] r;
		int          e;
		e = 0;
		r = 0;
		if (x == 0)
			return 0;
		while (e < 15 && (x >> (e + 1)) != 0)
			e++;
		m = 64'(x) << (30 - e);
		r = 64'(e) << 24;
		for (int i = 23; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= 64'h8000_0000) begin
				m = m >> 1;
				r[i] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] ln_fixed(input logic [15:0] x);
		return (log2_fixed(x) * 64'(LN2_Q30)) >> 30;
	endfunction

	// c1*ln(x/100) - c0, clamped
	function automatic logic [7:0] log_channel(input logic [63:0] c1, input logic [63:0] c0,
		input logic [15:0] x);
		logic [63:0] v;
		logic [63:0] k;
		logic [63:0] q;
		v = c1 * ln_fixed(x);
		k = c1 * ln_fixed(16'd100) + (c0 << 24);
		if (v <= k)
			return 8'd0;
		q = (v - k) >> 40;
		return q > 255 ? 8'd255 : q[7:0];
	endfunction

	// a*(u/100)^-p via exp series, clamped
	function automatic logic [7:0] power_channel(input logic [63:0] a, input logic [63:0] p,
		input logic [15:0] u);
		logic [63:0] lu;
		logic [63:0] lh;
		logic [63:0] lr;
		logic [63:0] y;
		logic [63:0] n;
		logic [63:0] f;
		logic [63:0] x;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] q;
		lu = log2_fixed(u);
		lh = log2_fixed(16'd100);
		lr = lu > lh ? lu - lh : 0;
		y = (p * lr) >> 24;
		n = (y >> 24) + 1;
		f = (n << 24) - y;
		x = (f * 64'(LN2_Q30)) >> 24;
		sum = 64'd1 << 30;
		term = 64'd1 << 30;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * x) >> 30) / k;
			sum += term;
		end
		if (46 + n >= 64)
			return 8'd0;
		q = (a * sum) >> (46 + n);
		return q > 255 ? 8'd255 : q[7:0];
	endfunction

	// full color of one temperature
	function automatic res_t color_of(input logic [15:0] kel);
		res_t c;
		int   r, g, b, mx, mn, d, num, off, h;
		if (kel <= KEL_LO_MAX) begin
			r = 255;
			g = kel == 0 ? 0 : log_channel(GRN_LO_C1, GRN_LO_C0, kel);
			b = kel <= KEL_BZ_MAX ? 0 : log_channel(BLU_C1, BLU_C0, kel - OFS_BLU);
		end else begin
			r = power_channel(RED_A, RED_P, kel - OFS_POW);
			g = power_channel(GRN_HI_A, GRN_HI_P, kel - OFS_POW);
			b = 255;
		end
		mx = r > g ? r : g;
		if (b > mx) mx = b;
		mn = r < g ? r : g;
		if (b < mn) mn = b;
		d = mx - mn;
		c.red = 8'(r);
		c.green = 8'(g);
		c.blue = 8'(b);
		c.brightness = 7'((200 * mx + 255) / 510);
		c.saturation = mx != 0 ? 7'((200 * d + mx) / (2 * mx)) : 7'd0;
		c.hue = 9'd0;
		if (d > 0) begin
			if (mx == r) begin
				num = g - b;
				off = 0;
			end else if (mx == g) begin
				num = b - r;
				off = 120;
			end else begin
				num = r - g;
				off = 240;
			end
			h = (120 * num + 121 * d) / (2 * d) - 60 + off;
			if (h < 0) h += 360;
			c.hue = 9'(h);
		end
		return c;
	endfunction

	// send one item, idling at random beforehand; valid stays high afterward
	task automatic send_kelvin(input logic [15:0] kel);
		while ($urandom_range(99) < send_idle_pct) begin
			kelvin_valid <= 1'b0;
			@(posedge clk);
		end
		kelvin_valid <= 1'b1;
		kelvin <= kel;
		@(posedge clk);
		while (kelvin_stall)
			@(posedge clk);
		colors_pending.push_back(color_of(kel));
	endtask

	task automatic wait_drained();
		kelvin_valid <= 1'b0;
		while (colors_pending.size() != 0)
			@(posedge clk);
	endtask

	// receiver stall pattern
	always @(posedge clk)
		color_stall <= $urandom_range(99) < recv_stall_pct;

	// result checker
	always @(posedge clk) begin
		res_t want;
		if (arst_n && color_valid && !color_stall) begin
			if (colors_pending.size() == 0) begin
				$display("%0t: unexpected item rgb=%0d,%0d,%0d", $time, red, green, blue);
				errors++;
			end else begin
				want = colors_pending.pop_front();
				if (red !== want.red) begin
					$display("%0t: red expected %0d actual %0d", $time, want.red, red);
					errors++;
				end
				if (green !== want.green) begin
					$display("%0t: green expected %0d actual %0d", $time, want.green, green);
					errors++;
				end
				if (blue !== want.blue) begin
					$display("%0t: blue expected %0d actual %0d", $time, want.blue, blue);
					errors++;
				end
				if (hue !== want.hue) begin
					$display("%0t: hue expected %0d actual %0d", $time, want.hue, hue);
					errors++;
				end
				if (saturation !== want.saturation) begin
					$display("%0t: saturation expected %0d actual %0d", $time,
						want.saturation, saturation);
					errors++;
				end
				if (brightness !== want.brightness) begin
					$display("%0t: brightness expected %0d actual %0d", $time,
						want.brightness, brightness);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((kelvin_valid && !kelvin_stall) || (color_valid && !color_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// breakpoints, extremes and the special cases
	task automatic test_directed();
		logic [15:0] points[$];
		points = '{16'd0, 16'd1, 16'd99, 16'd100, 16'd101, 16'd1000, 16'd1899, 16'd1900,
			16'd1901, 16'd2000, 16'd3000, 16'd4500, 16'd6500, 16'd6599, 16'd6600,
			16'd6601, 16'd6700, 16'd10000, 16'd20000, 16'd40000, 16'h8000, 16'h7fff,
			16'hfffe, 16'hffff, 16'h5555};
		foreach (points[i])
			send_kelvin(points[i]);
	endtask

	// random temperatures, mostly in the usual lighting range
	task automatic test_random(input int count);
		logic [15:0] kel;
		repeat (count) begin
			case ($urandom_range(3))
				0: kel = 16'($urandom_range(2000));
				1: kel = 16'($urandom_range(12000, 1000));
				2: kel = 16'($urandom_range(6800, 6400));
				default: kel = 16'($urandom);
			endcase
			send_kelvin(kel);
		end
	endtask

	// sender holds off until everything queued has come back
	task automatic test_drain_pause();
		test_random(20);
		wait_drained();
		test_random(20);
	endtask

	initial begin
		errors = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		kelvin_valid = 1'b0;
		kelvin = '0;
		color_stall = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(150);
		send_idle_pct = 76;
		test_random(120);
		send_idle_pct = 0;
		recv_stall_pct = 76;
		test_random(120);
		send_idle_pct = 14;
		recv_stall_pct = 14;
		test_drain_pause();
		test_random(140);

		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
